### design/brs_pkg.sv
// ----------------------------------------------------------------------------
// brs_pkg
// Shared types and constants of the bilinear image resizer.
// ----------------------------------------------------------------------------
`default_nettype none

package brs_pkg;

  // Default build sizes.
  localparam int MAX_SRC_DIM_DEF = 256;
  localparam int FRAC_BITS_DEF   = 8;

  // Field widths of the channels and registers.
  localparam int PIX_W     = 12;
  localparam int CHAN_W    = 8;
  localparam int RGB_W     = 3 * CHAN_W;
  localparam int SRC_CFG_W = 9;
  localparam int DST_CFG_W = 13;
  localparam int CFG_IDX_W = 2;

  // Depth of the result queue.
  localparam int OUT_DEPTH = 4;

  // Request codes.
  typedef enum logic {
    REQ_LOAD    = 1'b0,
    REQ_COMPUTE = 1'b1
  } req_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_ROWS = 2'd0,
    CFG_SRC_COLS = 2'd1,
    CFG_DST_ROWS = 2'd2,
    CFG_DST_COLS = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic              req_type;
    logic [PIX_W-1:0]  pix_row;
    logic [PIX_W-1:0]  pix_col;
    logic [CHAN_W-1:0] in_red;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
  } out_item_t;

endpackage

`default_nettype wire

### design/brs_stream_if.sv
// ----------------------------------------------------------------------------
// brs_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface brs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/brs_fifo.sv
// ----------------------------------------------------------------------------
// brs_fifo
// Small synchronous queue with a combinational read of the head entry.
// ----------------------------------------------------------------------------
`default_nettype none

module brs_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // Pointer advance with wrap at the queue depth.
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rptr_r];
  assign empty = (cnt_r == '0);

endmodule

`default_nettype wire

### design/brs_axis.sv
// ----------------------------------------------------------------------------
// brs_axis
// Source position of one axis: a multiply, a one-bit-per-stage restoring
// division and a final stage that forms both neighbor indexes and the weight.
// ----------------------------------------------------------------------------
`default_nettype none

module brs_axis
  import brs_pkg::*;
#(
  parameter int MAX_SRC_DIM = MAX_SRC_DIM_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  localparam int IW = (MAX_SRC_DIM > 1) ? $clog2(MAX_SRC_DIM) : 1
) (
  input  wire logic                 clk,
  input  wire logic [PIX_W-1:0]     dst_pos,
  input  wire logic [SRC_CFG_W-1:0] src_size,
  input  wire logic [DST_CFG_W-1:0] dst_size,
  output logic [IW-1:0]             lo_idx,
  output logic [IW-1:0]             hi_idx,
  output logic [FRAC_BITS-1:0]      weight
);
  localparam int F  = FRAC_BITS;
  localparam int SW = $clog2(MAX_SRC_DIM + 1);
  localparam int MW = PIX_W + SW;
  localparam int NW = DST_CFG_W;
  localparam int QW = IW + F;

  // Saturated sizes and the product in the first stage.
  logic [SW-1:0] s_clamp;
  logic [NW-1:0] n_fix;
  logic [MW-1:0] prod_r;
  logic [SW-1:0] s0_r;
  logic [NW-1:0] n0_r;
  logic          sat0_r;

  always_comb begin
    if (src_size == '0) begin
      s_clamp = SW'(1);
    end else if (int'(src_size) > MAX_SRC_DIM) begin
      s_clamp = SW'(MAX_SRC_DIM);
    end else begin
      s_clamp = SW'(src_size);
    end
    n_fix = (dst_size == '0) ? NW'(1) : dst_size;
  end

  always_ff @(posedge clk) begin
    prod_r <= MW'(dst_pos) * MW'(s_clamp);
    s0_r   <= s_clamp;
    n0_r   <= n_fix;
    sat0_r <= ({1'b0, dst_pos} >= n_fix);
  end

  // Division stages: each brings in one numerator bit and yields one quotient bit.
  logic [NW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [QW-1:0] q_r   [QW];
  logic [NW-1:0] n_r   [QW];
  logic [SW-1:0] s_r   [QW];
  logic          sat_r [QW];

  logic [NW-1:0] rem_in [QW];
  logic [QW-1:0] low_in [QW];
  logic [QW-1:0] q_in   [QW];
  logic [NW-1:0] n_in   [QW];
  logic [NW:0]   trial  [QW];
  logic          ge     [QW];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        rem_in[k] = NW'(prod_r >> IW);
        low_in[k] = {prod_r[IW-1:0], {F{1'b0}}};
        q_in[k]   = '0;
        n_in[k]   = n0_r;
      end else begin
        rem_in[k] = rem_r[k-1];
        low_in[k] = low_r[k-1];
        q_in[k]   = q_r[k-1];
        n_in[k]   = n_r[k-1];
      end
      trial[k] = {rem_in[k], low_in[k][QW-1]};
      ge[k]    = (trial[k] >= {1'b0, n_in[k]});
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      rem_r[k] <= ge[k] ? NW'(trial[k] - {1'b0, n_in[k]}) : NW'(trial[k]);
      low_r[k] <= {low_in[k][QW-2:0], 1'b0};
      q_r[k]   <= {q_in[k][QW-2:0], ge[k]};
      n_r[k]   <= n_in[k];
      s_r[k]   <= (k == 0) ? s0_r : s_r[k-1];
      sat_r[k] <= (k == 0) ? sat0_r : sat_r[k-1];
    end
  end

  // Neighbors and weight from the position; the edge repeats past the image.
  logic [QW-1:0] pos;
  logic [F-1:0]  frac;
  logic [SW-1:0] smax;
  logic [IW-1:0] a_raw;
  logic [IW:0]   b_raw;
  logic [QW:0]   pos_up;
  logic [IW-1:0] lo_nxt, hi_nxt;
  logic [F-1:0]  w_nxt;

  always_comb begin
    pos    = q_r[QW-1];
    frac   = pos[F-1:0];
    smax   = s_r[QW-1] - 1'b1;
    a_raw  = (pos >= QW'(1 << (F - 1))) ? IW'((pos - QW'(1 << (F - 1))) >> F) : '0;
    pos_up = {1'b0, pos} + (QW + 1)'(1 << (F - 1));
    b_raw  = (IW + 1)'(pos_up >> F);
    w_nxt  = (frac < F'(1 << (F - 1))) ? frac + F'(1 << (F - 1))
                                       : frac - F'(1 << (F - 1));
    lo_nxt = ((SW + 1)'(a_raw) > (SW + 1)'(smax)) ? IW'(smax) : a_raw;
    hi_nxt = ((SW + 1)'(b_raw) > (SW + 1)'(smax)) ? IW'(smax) : IW'(b_raw);
    if (sat_r[QW-1]) begin
      lo_nxt = IW'(smax);
      hi_nxt = IW'(smax);
      w_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    lo_idx <= lo_nxt;
    hi_idx <= hi_nxt;
    weight <= w_nxt;
  end

endmodule

`default_nettype wire

### design/brs_engine.sv
// ----------------------------------------------------------------------------
// brs_engine
// Source image memory with its sequencer: writes loaded pixels, reads the
// four neighbors of a destination pixel and blends them.
// ----------------------------------------------------------------------------
`default_nettype none

module brs_engine
  import brs_pkg::*;
#(
  parameter int MAX_SRC_DIM = MAX_SRC_DIM_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  localparam int IW = (MAX_SRC_DIM > 1) ? $clog2(MAX_SRC_DIM) : 1,
  localparam int AW = $clog2(MAX_SRC_DIM * MAX_SRC_DIM)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 job_vld,
  input  wire logic                 job_req,
  input  wire logic                 job_ok,
  input  wire logic [AW-1:0]        job_addr,
  input  wire logic [RGB_W-1:0]     job_rgb,
  input  wire logic [IW-1:0]        job_top,
  input  wire logic [IW-1:0]        job_bot,
  input  wire logic [IW-1:0]        job_left,
  input  wire logic [IW-1:0]        job_right,
  input  wire logic [FRAC_BITS-1:0] job_wx,
  input  wire logic [FRAC_BITS-1:0] job_wy,
  output logic                      job_pop,
  output logic                      out_push,
  output logic [RGB_W-1:0]          out_rgb,
  input  wire logic                 out_take
);
  localparam int F     = FRAC_BITS;
  localparam int DEPTH = MAX_SRC_DIM * MAX_SRC_DIM;
  localparam int OCW   = $clog2(OUT_DEPTH + 1);

  // One channel blend: a + (b - a) * w, truncated.
  function automatic logic [CHAN_W-1:0] blend_ch(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b,
                                                 input logic [F-1:0] w);
    logic [F+CHAN_W:0] acc;
    acc = (F + CHAN_W + 1)'(a) * (F + CHAN_W + 1)'((F + 1)'(1 << F) - (F + 1)'(w))
        + (F + CHAN_W + 1)'(b) * (F + CHAN_W + 1)'(w);
    return acc[F+CHAN_W-1:F];
  endfunction

  function automatic logic [RGB_W-1:0] blend_px(input logic [RGB_W-1:0] a,
                                                input logic [RGB_W-1:0] b,
                                                input logic [F-1:0] w);
    logic [RGB_W-1:0] r;
    for (int c = 0; c < 3; c++) begin
      r[c*CHAN_W +: CHAN_W] = blend_ch(a[c*CHAN_W +: CHAN_W], b[c*CHAN_W +: CHAN_W], w);
    end
    return r;
  endfunction

  // Sequencer: a load holds the memory for one write, a compute for its four neighbor reads.
  logic             busy_r, busy_nxt;
  logic [1:0]       ph_r, ph_nxt;
  logic             last;
  logic             j_req_r, j_ok_r;
  logic [AW-1:0]    j_addr_r;
  logic [RGB_W-1:0] j_rgb_r;
  logic [IW-1:0]    j_top_r, j_bot_r, j_left_r, j_right_r;
  logic [F-1:0]     j_wx_r, j_wy_r;
  logic [OCW-1:0]   ocred_r, ocred_nxt;
  logic             credit_ok;

  assign last      = busy_r && ((j_req_r == REQ_LOAD) || (ph_r == 2'd3));
  assign credit_ok = (job_req == REQ_LOAD) || (int'(ocred_r) < OUT_DEPTH);
  assign job_pop   = job_vld && (!busy_r || last) && credit_ok;

  always_comb begin
    busy_nxt = busy_r;
    ph_nxt   = ph_r;
    if (job_pop) begin
      busy_nxt = 1'b1;
      ph_nxt   = '0;
    end else if (last) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      ph_nxt = ph_r + 1'b1;
    end
    ocred_nxt = ocred_r;
    if (job_pop && (job_req == REQ_COMPUTE) && !out_take) begin
      ocred_nxt = ocred_r + 1'b1;
    end else if (out_take && !(job_pop && (job_req == REQ_COMPUTE))) begin
      ocred_nxt = ocred_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      ph_r    <= '0;
      ocred_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      ph_r    <= ph_nxt;
      ocred_r <= ocred_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      j_req_r   <= job_req;
      j_ok_r    <= job_ok;
      j_addr_r  <= job_addr;
      j_rgb_r   <= job_rgb;
      j_top_r   <= job_top;
      j_bot_r   <= job_bot;
      j_left_r  <= job_left;
      j_right_r <= job_right;
      j_wx_r    <= job_wx;
      j_wy_r    <= job_wy;
    end
  end

  // Memory address: neighbor order is top-left, top-right, bottom-left, bottom-right.
  logic          mem_we, mem_re;
  logic [IW-1:0] rd_row, rd_col;
  logic [AW-1:0] maddr;

  always_comb begin
    mem_we = busy_r && (j_req_r == REQ_LOAD) && j_ok_r;
    mem_re = busy_r && (j_req_r == REQ_COMPUTE);
    rd_row = ph_r[1] ? j_bot_r : j_top_r;
    rd_col = ph_r[0] ? j_right_r : j_left_r;
    maddr  = (j_req_r == REQ_LOAD) ? j_addr_r
                                   : AW'(AW'(rd_row) * AW'(MAX_SRC_DIM) + AW'(rd_col));
  end

  logic [RGB_W-1:0] mem_r [DEPTH];
  logic [RGB_W-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[maddr] <= j_rgb_r;
    end else begin
      rd_r <= mem_r[maddr];
    end
  end

  // Tags that travel with each read.
  logic         rv_r;
  logic [1:0]   rk_r;
  logic [F-1:0] wx_t_r, wy_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
    end else begin
      rv_r <= mem_re;
    end
  end

  always_ff @(posedge clk) begin
    rk_r   <= ph_r;
    wx_t_r <= j_wx_r;
    wy_t_r <= j_wy_r;
  end

  // Horizontal blends as the neighbor pairs arrive.
  logic [RGB_W-1:0] p0_r, p2_r, t_r, b_r;
  logic [F-1:0]     wy2_r;
  logic             vv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vv_r <= 1'b0;
    end else begin
      vv_r <= rv_r && (rk_r == 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (rv_r) begin
      unique case (rk_r)
        2'd0: p0_r <= rd_r;
        2'd1: t_r  <= blend_px(p0_r, rd_r, wx_t_r);
        2'd2: p2_r <= rd_r;
        2'd3: begin
          b_r   <= blend_px(p2_r, rd_r, wx_t_r);
          wy2_r <= wy_t_r;
        end
        default: ;
      endcase
    end
  end

  // Vertical blend goes straight into the result queue.
  assign out_push = vv_r;
  assign out_rgb  = blend_px(t_r, b_r, wy2_r);

endmodule

`default_nettype wire

### design/bilinear_image_resize.sv
// ----------------------------------------------------------------------------
// bilinear_image_resize
// Bilinear RGB image scaler with an on-chip source image memory.
// ----------------------------------------------------------------------------
// A load transaction writes one source pixel, if it lies inside the store,
// and gives no result; a compute transaction gives one interpolated pixel.
// Loads are taken one per cycle while the job queue has room. Compute
// transactions are taken back to back until it fills, and the engine serves
// them in turn with four neighbor reads each from the single-port image
// memory. Most of a compute's path lies in the one-bit-per-stage division of
// each axis. The image memory is not cleared: a pixel must be loaded before
// it is used. Size registers may be written only while the block is idle.
`default_nettype none

module bilinear_image_resize
  import brs_pkg::*;
#(
  parameter int MAX_SRC_DIM = MAX_SRC_DIM_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  brs_stream_if.sink                in_s,
  brs_stream_if.source              out_s,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [DST_CFG_W-1:0] cfg_wdata
);
  localparam int F   = FRAC_BITS;
  localparam int IW  = (MAX_SRC_DIM > 1) ? $clog2(MAX_SRC_DIM) : 1;
  localparam int AW  = $clog2(MAX_SRC_DIM * MAX_SRC_DIM);
  localparam int LAT = IW + F + 2;
  localparam int JD  = 1 << $clog2(LAT + 4);
  localparam int JCW = $clog2(JD + 1);

  // Size registers.
  logic [SRC_CFG_W-1:0] src_rows_r, src_cols_r;
  logic [DST_CFG_W-1:0] dst_rows_r, dst_cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_rows_r <= SRC_CFG_W'(256);
      src_cols_r <= SRC_CFG_W'(256);
      dst_rows_r <= DST_CFG_W'(256);
      dst_cols_r <= DST_CFG_W'(256);
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_SRC_ROWS: src_rows_r <= cfg_wdata[SRC_CFG_W-1:0];
        CFG_SRC_COLS: src_cols_r <= cfg_wdata[SRC_CFG_W-1:0];
        CFG_DST_ROWS: dst_rows_r <= cfg_wdata;
        CFG_DST_COLS: dst_cols_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Credits cover every item in the position pipeline and the job queue.
  logic           in_acc, job_pop;
  logic [JCW-1:0] cred_r;

  assign in_s.ready = (int'(cred_r) < JD);
  assign in_acc     = in_s.valid && in_s.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cred_r <= '0;
    end else if (in_acc && !job_pop) begin
      cred_r <= cred_r + 1'b1;
    end else if (job_pop && !in_acc) begin
      cred_r <= cred_r - 1'b1;
    end
  end

  // Position math for both axes.
  logic [IW-1:0] top, bot, left, right;
  logic [F-1:0]  wx, wy;

  brs_axis #(.MAX_SRC_DIM(MAX_SRC_DIM), .FRAC_BITS(FRAC_BITS)) u_row_axis (
    .clk      (clk),
    .dst_pos  (in_s.data.pix_row),
    .src_size (src_rows_r),
    .dst_size (dst_rows_r),
    .lo_idx   (top),
    .hi_idx   (bot),
    .weight   (wy)
  );

  brs_axis #(.MAX_SRC_DIM(MAX_SRC_DIM), .FRAC_BITS(FRAC_BITS)) u_col_axis (
    .clk      (clk),
    .dst_pos  (in_s.data.pix_col),
    .src_size (src_cols_r),
    .dst_size (dst_cols_r),
    .lo_idx   (left),
    .hi_idx   (right),
    .weight   (wx)
  );

  // Delay line for the rest of each item, aligned with the axis results.
  logic             pv_r    [LAT];
  logic             preq_r  [LAT];
  logic             pok_r   [LAT];
  logic [AW-1:0]    paddr_r [LAT];
  logic [RGB_W-1:0] prgb_r  [LAT];
  logic             ld_ok;

  assign ld_ok = (int'(in_s.data.pix_row) < MAX_SRC_DIM)
              && (int'(in_s.data.pix_col) < MAX_SRC_DIM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) begin
        pv_r[k] <= 1'b0;
      end
    end else begin
      for (int k = 0; k < LAT; k++) begin
        pv_r[k] <= (k == 0) ? in_acc : pv_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < LAT; k++) begin
      if (k == 0) begin
        preq_r[k]  <= in_s.data.req_type;
        pok_r[k]   <= ld_ok;
        paddr_r[k] <= AW'(AW'(in_s.data.pix_row) * AW'(MAX_SRC_DIM)
                        + AW'(in_s.data.pix_col));
        prgb_r[k]  <= {in_s.data.in_red, in_s.data.in_green, in_s.data.in_blue};
      end else begin
        preq_r[k]  <= preq_r[k-1];
        pok_r[k]   <= pok_r[k-1];
        paddr_r[k] <= paddr_r[k-1];
        prgb_r[k]  <= prgb_r[k-1];
      end
    end
  end

  // Job queue in front of the memory sequencer.
  typedef struct packed {
    logic             req;
    logic             ok;
    logic [AW-1:0]    addr;
    logic [RGB_W-1:0] rgb;
    logic [IW-1:0]    top;
    logic [IW-1:0]    bot;
    logic [IW-1:0]    left;
    logic [IW-1:0]    right;
    logic [F-1:0]     wx;
    logic [F-1:0]     wy;
  } job_t;

  job_t job_in, job_out;
  logic job_empty;

  assign job_in = '{req: preq_r[LAT-1], ok: pok_r[LAT-1], addr: paddr_r[LAT-1],
                    rgb: prgb_r[LAT-1], top: top, bot: bot, left: left,
                    right: right, wx: wx, wy: wy};

  brs_fifo #(.W($bits(job_t)), .DEPTH(JD)) u_job_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (pv_r[LAT-1]),
    .wdata (job_in),
    .pop   (job_pop),
    .rdata (job_out),
    .empty (job_empty)
  );

  // Memory and blend.
  logic             out_push, out_take, out_empty;
  logic [RGB_W-1:0] out_rgb, out_head;

  brs_engine #(.MAX_SRC_DIM(MAX_SRC_DIM), .FRAC_BITS(FRAC_BITS)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_vld   (!job_empty),
    .job_req   (job_out.req),
    .job_ok    (job_out.ok),
    .job_addr  (job_out.addr),
    .job_rgb   (job_out.rgb),
    .job_top   (job_out.top),
    .job_bot   (job_out.bot),
    .job_left  (job_out.left),
    .job_right (job_out.right),
    .job_wx    (job_out.wx),
    .job_wy    (job_out.wy),
    .job_pop   (job_pop),
    .out_push  (out_push),
    .out_rgb   (out_rgb),
    .out_take  (out_take)
  );

  // Result queue decouples the output side.
  brs_fifo #(.W(RGB_W), .DEPTH(OUT_DEPTH)) u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (out_push),
    .wdata (out_rgb),
    .pop   (out_take),
    .rdata (out_head),
    .empty (out_empty)
  );

  assign out_s.valid = !out_empty;
  assign out_s.data  = out_item_t'(out_head);
  assign out_take    = out_s.valid && out_s.ready;

endmodule

`default_nettype wire

### design/brs_checker.sv
// ----------------------------------------------------------------------------
// brs_checker
// Port-level checks of the bilinear image resizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module brs_checker
  import brs_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             in_req,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [RGB_W-1:0] out_data
);
  // Compute transactions accepted whose results are not yet taken.
  logic [15:0] pend_r;
  logic        add, sub;

  assign add = in_valid && in_ready && (in_req == REQ_COMPUTE);
  assign sub = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (add && !sub) begin
      pend_r <= pend_r + 1'b1;
    end else if (sub && !add) begin
      pend_r <= pend_r - 1'b1;
    end
  end

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // No result without an outstanding compute transaction.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("result without a compute request");

  // Reset leaves no result and an open input.
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_reset_in: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind bilinear_image_resize brs_checker u_brs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_s.valid),
  .in_ready  (in_s.ready),
  .in_req    (in_s.data.req_type),
  .out_valid (out_s.valid),
  .out_ready (out_s.ready),
  .out_data  (out_s.data)
);

`default_nettype wire

### bench/tb_bilinear_image_resize.sv
// ----------------------------------------------------------------------------
// tb_bilinear_image_resize
// Self-checking bench for the bilinear RGB image scaler.
// ----------------------------------------------------------------------------
// Source pixels are loaded and destination pixels requested over the input
// stream. An in-bench predictor keeps its own copy of the image memory and of
// the size registers and works out every interpolated pixel, which is checked
// against the result stream in order. The run steps through several size
// settings, the extremes among them, with random idling on both streams. A
// compute transaction is only sent when all four of its neighbors have been
// loaded.
`default_nettype none

module tb_bilinear_image_resize;
  import brs_pkg::*;

  localparam int STORE_DIM  = 256;
  localparam int SETTLE_CYC = 60;

  // Predictor of the scaler with its own image memory and size registers.
  class resize_scoreboard;
    bit [RGB_W-1:0]     pix_mem [STORE_DIM*STORE_DIM];
    bit                 loaded  [STORE_DIM*STORE_DIM];
    int                 loaded_q[$];
    bit [SRC_CFG_W-1:0] src_rows = 256, src_cols = 256;
    bit [DST_CFG_W-1:0] dst_rows = 256, dst_cols = 256;
    out_item_t          expected_q[$];
    int                 errors = 0, results = 0, loads = 0, computes = 0;

    function void set_reg(cfg_idx_t idx, bit [DST_CFG_W-1:0] val);
      case (idx)
        CFG_SRC_ROWS: src_rows = val[SRC_CFG_W-1:0];
        CFG_SRC_COLS: src_cols = val[SRC_CFG_W-1:0];
        CFG_DST_ROWS: dst_rows = val;
        CFG_DST_COLS: dst_cols = val;
      endcase
    endfunction

    function int unsigned eff_src(bit [SRC_CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > STORE_DIM) return STORE_DIM;
      return v;
    endfunction

    // Neighbor indices and weight along one axis.
    function void axis_map(int unsigned d, bit [SRC_CFG_W-1:0] sv, bit [DST_CFG_W-1:0] nv,
                           output int unsigned lo, output int unsigned hi,
                           output int unsigned w);
      int unsigned s, n, pos, f;
      s   = eff_src(sv);
      n   = (nv == 0) ? 1 : nv;
      pos = ((d * s) << FRAC_BITS_DEF) / n;
      f   = pos & 8'hFF;
      w   = (f < 128) ? f + 128 : f - 128;
      lo  = (pos >= 128) ? (pos - 128) >> FRAC_BITS_DEF : 0;
      hi  = (pos + 128) >> FRAC_BITS_DEF;
      if (lo > s - 1) lo = s - 1;
      if (hi > s - 1) hi = s - 1;
    endfunction

    function bit [7:0] mix(int unsigned a, int unsigned b, int unsigned w);
      return 8'((a * (256 - w) + b * w) >> FRAC_BITS_DEF);
    endfunction

    // Interpolated pixel for a destination position; ok is low when a neighbor
    // has not been loaded yet.
    function void interpolate(int unsigned row, int unsigned col,
                              output out_item_t res, output bit ok);
      int unsigned top, bot, lft, rgt, wy, wx, sh, t, b;
      bit [RGB_W-1:0] p [4];
      axis_map(row, src_rows, dst_rows, top, bot, wy);
      axis_map(col, src_cols, dst_cols, lft, rgt, wx);
      ok = loaded[top*STORE_DIM+lft] && loaded[top*STORE_DIM+rgt] &&
           loaded[bot*STORE_DIM+lft] && loaded[bot*STORE_DIM+rgt];
      p[0] = pix_mem[top*STORE_DIM+lft];
      p[1] = pix_mem[top*STORE_DIM+rgt];
      p[2] = pix_mem[bot*STORE_DIM+lft];
      p[3] = pix_mem[bot*STORE_DIM+rgt];
      for (int ch = 0; ch < 3; ch++) begin
        sh = 16 - 8 * ch;
        t  = mix((p[0] >> sh) & 8'hFF, (p[1] >> sh) & 8'hFF, wx);
        b  = mix((p[2] >> sh) & 8'hFF, (p[3] >> sh) & 8'hFF, wx);
        res[sh +: 8] = mix(t, b, wy);
      end
    endfunction

    // Record an accepted input transaction.
    function void note_input(in_item_t it);
      out_item_t res;
      bit ok;
      int idx;
      if (it.req_type == REQ_LOAD) begin
        loads++;
        if (it.pix_row < STORE_DIM && it.pix_col < STORE_DIM) begin
          idx = it.pix_row * STORE_DIM + it.pix_col;
          pix_mem[idx] = {it.in_red, it.in_green, it.in_blue};
          if (!loaded[idx]) loaded_q.push_back(idx);
          loaded[idx] = 1;
        end
      end else begin
        computes++;
        interpolate(it.pix_row, it.pix_col, res, ok);
        expected_q.push_back(res);
      end
    endfunction

    // Compare an accepted result with the oldest expectation.
    function void check_result(out_item_t got);
      out_item_t exp;
      results++;
      if (expected_q.size() == 0) begin
        $display("%0t: result %h with no expectation waiting", $time, got);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.out_red !== exp.out_red) begin
        $display("%0t: red expected %h actual %h", $time, exp.out_red, got.out_red);
        errors++;
      end
      if (got.out_green !== exp.out_green) begin
        $display("%0t: green expected %h actual %h", $time, exp.out_green, got.out_green);
        errors++;
      end
      if (got.out_blue !== exp.out_blue) begin
        $display("%0t: blue expected %h actual %h", $time, exp.out_blue, got.out_blue);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic                 cfg_wr_en = 0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [DST_CFG_W-1:0] cfg_wdata = '0;

  brs_stream_if #(.payload_t(in_item_t))  in_ch ();
  brs_stream_if #(.payload_t(out_item_t)) out_ch ();

  resize_scoreboard sb = new();
  bit calm = 0;
  int hold_req = 0;

  bilinear_image_resize DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_ch),
    .out_s     (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Handshakes are sampled mid-cycle, where every signal is stable.
  always @(negedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_input(in_ch.data);
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  // Result receiver: random stall bursts, plus long hold-offs on request.
  initial begin
    int n;
    out_ch.ready = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        out_ch.ready <= 0;
        repeat (n - 1) @(posedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 0;
        repeat ($urandom_range(1, 18) - 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1;
      end
    end
  end

  // Send one transaction; returns at the clock edge that accepts it.
  task automatic send_item(in_item_t it);
    in_ch.valid <= 1;
    in_ch.data  <= it;
    forever begin
      @(negedge clk);
      if (in_ch.ready) break;
    end
    @(posedge clk);
  endtask

  task automatic sender_gap(int n);
    in_ch.valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 5) == 0) sender_gap($urandom_range(1, 18));
  endtask

  // Wait until every expected result has come, then let the pipeline drain.
  task automatic wait_idle();
    sender_gap(1);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic load_pixel(int unsigned r, int unsigned c);
    in_item_t it;
    it.req_type = REQ_LOAD;
    it.pix_row  = PIX_W'(r);
    it.pix_col  = PIX_W'(c);
    it.in_red   = CHAN_W'($urandom);
    it.in_green = CHAN_W'($urandom);
    it.in_blue  = CHAN_W'($urandom);
    send_item(it);
  endtask

  task automatic compute_pixel(int unsigned r, int unsigned c);
    in_item_t it;
    it.req_type = REQ_COMPUTE;
    it.pix_row  = PIX_W'(r);
    it.pix_col  = PIX_W'(c);
    it.in_red   = CHAN_W'($urandom);
    it.in_green = CHAN_W'($urandom);
    it.in_blue  = CHAN_W'($urandom);
    send_item(it);
  endtask

  task automatic write_sizes(int sr, int sc, int dr, int dc);
    @(posedge clk);
    cfg_wr_en <= 1; cfg_idx <= CFG_SRC_ROWS; cfg_wdata <= DST_CFG_W'(sr);
    sb.set_reg(CFG_SRC_ROWS, DST_CFG_W'(sr));
    @(posedge clk);
    cfg_idx <= CFG_SRC_COLS; cfg_wdata <= DST_CFG_W'(sc);
    sb.set_reg(CFG_SRC_COLS, DST_CFG_W'(sc));
    @(posedge clk);
    cfg_idx <= CFG_DST_ROWS; cfg_wdata <= DST_CFG_W'(dr);
    sb.set_reg(CFG_DST_ROWS, DST_CFG_W'(dr));
    @(posedge clk);
    cfg_idx <= CFG_DST_COLS; cfg_wdata <= DST_CFG_W'(dc);
    sb.set_reg(CFG_DST_COLS, DST_CFG_W'(dc));
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  // Random destination request, mostly near a loaded pixel, only if all four
  // neighbors are loaded; otherwise falls back to a load.
  task automatic random_compute();
    int unsigned s_r, s_c, r, c, idx;
    out_item_t res;
    bit ok;
    s_r = sb.eff_src(sb.src_rows);
    s_c = sb.eff_src(sb.src_cols);
    for (int t = 0; t < 16; t++) begin
      if ($urandom_range(0, 7) == 0) begin
        r = $urandom_range(0, 4095);
        c = $urandom_range(0, 4095);
      end else begin
        idx = sb.loaded_q[$urandom_range(0, sb.loaded_q.size() - 1)];
        r = (idx / STORE_DIM) * ((sb.dst_rows == 0) ? 1 : sb.dst_rows) / s_r;
        c = (idx % STORE_DIM) * ((sb.dst_cols == 0) ? 1 : sb.dst_cols) / s_c;
        r = r + $urandom_range(0, 2);
        c = c + $urandom_range(0, 2);
        r = (r > 0) ? r - 1 : 0;
        c = (c > 0) ? c - 1 : 0;
        if (r > 4095) r = 4095;
        if (c > 4095) c = 4095;
      end
      sb.interpolate(r, c, res, ok);
      if (ok) begin
        compute_pixel(r, c);
        return;
      end
    end
    load_pixel($urandom_range(0, s_r - 1), $urandom_range(0, s_c - 1));
  endtask

  // One size setting: load the image region, then a random mix.
  task automatic run_phase(int sr, int sc, int dr, int dc, int items, bit squeeze);
    int unsigned s_r, s_c, k;
    write_sizes(sr, sc, dr, dc);
    s_r = sb.eff_src(SRC_CFG_W'(sr));
    s_c = sb.eff_src(SRC_CFG_W'(sc));
    if (s_r * s_c <= 300) begin
      for (int r = 0; r < s_r; r++)
        for (int c = 0; c < s_c; c++) begin
          load_pixel(r, c);
          maybe_gap();
        end
    end else begin
      load_pixel(0, 0);
      load_pixel(0, s_c - 1);
      load_pixel(s_r - 1, 0);
      load_pixel(s_r - 1, s_c - 1);
      repeat (40) load_pixel($urandom_range(0, s_r - 1), $urandom_range(0, s_c - 1));
    end
    for (int i = 0; i < items; i++) begin
      if (squeeze && i == 10) hold_req = 300;
      if (squeeze && i == items / 2) wait_idle();
      k = $urandom_range(0, 19);
      if (k < 3)
        load_pixel($urandom_range(0, s_r - 1), $urandom_range(0, s_c - 1));
      else if (k == 3)
        load_pixel($urandom_range(0, 255), $urandom_range(0, 255));
      else if (k == 4)
        load_pixel($urandom_range(256, 4095), $urandom_range(0, 4095));
      else
        random_compute();
      maybe_gap();
    end
    wait_idle();
  endtask

  // Timeout guard.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // Main stimulus.
  initial begin
    in_item_t it;
    in_ch.valid = 0;
    in_ch.data  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: field extremes, loads outside the store, edge repeats.
    write_sizes(256, 256, 256, 256);
    it = '0;
    it.req_type = REQ_LOAD;
    send_item(it);
    it = '1;
    it.req_type = REQ_LOAD;
    it.pix_row = 255;
    it.pix_col = 255;
    send_item(it);
    load_pixel(4095, 0);
    load_pixel(0, 256);
    load_pixel(4095, 4095);
    load_pixel(0, 1);
    load_pixel(1, 0);
    load_pixel(1, 1);
    load_pixel(254, 254);
    load_pixel(254, 255);
    load_pixel(255, 254);
    compute_pixel(0, 0);
    compute_pixel(1, 1);
    compute_pixel(255, 255);
    compute_pixel(4095, 4095);
    compute_pixel(256, 300);
    it = '1;
    it.req_type = REQ_COMPUTE;
    it.pix_row = 0;
    it.pix_col = 0;
    send_item(it);
    wait_idle();

    // Size settings, extremes first, then random ones.
    run_phase(256, 256, 256, 256, 40, 0);
    run_phase(1, 1, 1, 1, 30, 0);
    run_phase(0, 0, 0, 0, 20, 0);
    run_phase(511, 2, 8191, 4096, 120, 1);
    run_phase(4, 7, 4096, 3, 40, 0);
    run_phase(16, 16, 5, 40, 120, 1);
    run_phase(256, 1, 1, 4096, 30, 0);
    repeat (2)
      run_phase($urandom_range(1, 12), $urandom_range(1, 12),
                $urandom_range(1, 64), $urandom_range(1, 64), 40, 0);
    calm = 1;
    run_phase($urandom_range(2, 10), $urandom_range(2, 10),
              $urandom_range(1, 40), $urandom_range(1, 40), 60, 0);

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    $display("Covered %0d loads and %0d compute requests, %0d results checked,",
             sb.loads, sb.computes, sb.results);
    $display("across size settings from 1x1 up to the full store and 8191-wide outputs.");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
design/brs_pkg.sv
design/brs_stream_if.sv
design/brs_fifo.sv
design/brs_axis.sv
design/brs_engine.sv
design/bilinear_image_resize.sv
design/brs_checker.sv
bench/tb_bilinear_image_resize.sv
